[src/assert_macros.svh]
// Assertion macros shared by the delay block's RTL files.
// Depends on nothing; included by the modules that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SFD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sfd_pkg.sv]
// Shared constants, codes and types of the stereo feedback delay block.
// Depends on nothing; imported by every module of the block except sfd_ram.
package sfd_pkg;

   localparam int LINE_DEPTH_DEF  = 131072;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int DELAY_BITS     = 17;
   localparam int GAIN_BITS      = 16;
   localparam int CSR_DATA_BITS  = 17;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 17'd24000;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd16384;
   localparam logic [GAIN_BITS-1:0]  FB_UNITY    = 16'd32768;
   localparam logic [15:0]           DC_COEF     = 16'd65208;

   // blocker state and arithmetic widths
   localparam int DC_BITS   = 32;
   localparam int PROD_BITS = 49;
   localparam int YSUM_BITS = 35;
   localparam int LSUM_BITS = 36;

   localparam logic signed [PROD_BITS-1:0] DC_ROUND = 49'sd32768;
   localparam logic signed [PROD_BITS-1:0] FB_ROUND = 49'sd16384;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DELAY = 1'b0,
      CSR_GAIN  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_BLOCK,
      BK_FEED,
      BK_WRITE
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[src/sfd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/sfd_queue.sv]
// Short queue of decoded frames between the front and back of the delay block.
// Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_queue
   import sfd_pkg::*;
#(
   parameter int WIDTH = 97
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam logic [PW:0] FULL_COUNT = (PW+1)'(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);

   `SFD_ASSERT_IMPLY(a_no_overflow, clock, reset, push && !pop, count_ff < FULL_COUNT,
      "queue pushed while full")

endmodule

[src/sfd_front.sv]
// Front of the delay block: takes frames, tracks the write slot and line fill,
// reduces the delay modulo the line depth and queues decoded frames. Uses sfd_pkg.
`include "assert_macros.svh"

module sfd_front
   import sfd_pkg::*;
#(
   parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_left_in,
   input  logic [SAMPLE_BITS-1:0]    req_right_in,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  queue_status_type          q_status,
   output logic                      q_push,
   output logic [2*SAMPLE_BITS+2*$clog2(LINE_DEPTH):0] q_data
);

   localparam int AW        = $clog2(LINE_DEPTH);
   localparam int DIV_BITS  = AW + DELAY_BITS;
   localparam int RCP_SHIFT = AW + DELAY_BITS;
   localparam int RCP_BITS  = DELAY_BITS + 2;
   localparam int MUL_BITS  = RCP_SHIFT + DELAY_BITS;
   localparam longint RCP_L = (longint'(1) <<< RCP_SHIFT) / LINE_DEPTH;
   localparam logic [RCP_BITS-1:0] RECIP = RCP_BITS'(RCP_L);
   localparam logic [1:0] RED_STEPS = 2'd3;
   localparam logic [1:0] STEP_QUOT = 2'd3;
   localparam logic [1:0] STEP_PROD = 2'd2;
   localparam logic [1:0] STEP_REM  = 2'd1;
   localparam logic [AW-1:0] DEPTH_LOW = AW'(LINE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_DEPTH - 1);
   localparam logic [DIV_BITS-1:0] DEPTH_WIDE = DIV_BITS'(LINE_DEPTH);

   logic [DELAY_BITS-1:0] dly_ff, dly_in;
   logic [DELAY_BITS-1:0] quo_ff, quo_in;
   logic [DELAY_BITS-1:0] prod_ff, prod_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic                  wrapped_ff, wrapped_in;

   logic                  reducing;
   logic                  req_fire;
   logic [DIV_BITS-1:0]   dly_wide;
   logic [MUL_BITS-1:0]   quo_full;
   logic [DIV_BITS-1:0]   prod_full;
   logic [DELAY_BITS-1:0] rem;
   logic [AW-1:0]         d_addr;
   logic [AW:0]           diff;
   logic [AW-1:0]         rd_addr;
   logic                  rd_valid;

   assign reducing  = (cnt_ff != '0);
   assign req_stall = reducing || q_status.full;
   assign req_fire  = req_valid && !req_stall;
   assign dly_wide  = DIV_BITS'(dly_ff);
   assign d_addr    = dly_wide[AW-1:0];

   // reciprocal reduction: estimate the quotient, form quotient times depth,
   // then subtract and correct once; one step per cycle
   always_comb begin
      quo_full  = MUL_BITS'(dly_ff) * MUL_BITS'(RECIP);
      prod_full = DIV_BITS'(quo_ff) * DEPTH_WIDE;
      rem       = dly_ff - prod_ff;
      if (DIV_BITS'(rem) >= DEPTH_WIDE) begin
         rem = rem - DEPTH_WIDE[DELAY_BITS-1:0];
      end
      dly_in  = dly_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      if (csr_write && (csr_index == CSR_DELAY)) begin
         dly_in = csr_data[DELAY_BITS-1:0];
         cnt_in = RED_STEPS;
      end else if (reducing) begin
         case (cnt_ff)
            STEP_QUOT: quo_in  = quo_full[RCP_SHIFT +: DELAY_BITS];
            STEP_PROD: prod_in = prod_full[DELAY_BITS-1:0];
            STEP_REM:  dly_in  = rem;
            default:   dly_in  = dly_ff;
         endcase
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // read slot trails the write slot; wrap with the low bits of the depth
   always_comb begin
      diff    = {1'b0, wp_ff} - {1'b0, d_addr};
      rd_addr = diff[AW] ? diff[AW-1:0] + DEPTH_LOW : diff[AW-1:0];
      rd_valid = wrapped_ff || (rd_addr < wp_ff);
   end

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (req_fire) begin
         if (wp_ff == LAST_SLOT) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff     <= DELAY_RESET;
         quo_ff     <= '0;
         prod_ff    <= '0;
         cnt_ff     <= RED_STEPS;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         dly_ff     <= dly_in;
         quo_ff     <= quo_in;
         prod_ff    <= prod_in;
         cnt_ff     <= cnt_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   assign q_push = req_fire;
   assign q_data = {req_left_in, req_right_in, wp_ff, rd_addr, rd_valid};

   `SFD_ASSERT_IMPLY(a_delay_reduced, clock, reset, !reducing, dly_wide < DEPTH_WIDE,
      "delay not below line depth after reduction")
   `SFD_ASSERT_IMPLY(a_push_room, clock, reset, q_push, !q_status.full,
      "frame pushed into a full queue")

endmodule

[src/sfd_back.sv]
// Back of the delay block: reads the line, runs the DC blocker and feedback,
// writes the line and holds the result word. Uses sfd_pkg and sfd_ram.
`include "assert_macros.svh"

module sfd_back
   import sfd_pkg::*;
#(
   parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  queue_status_type          q_status,
   output logic                      q_pop,
   input  logic [2*SAMPLE_BITS+2*$clog2(LINE_DEPTH):0] q_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_left_out,
   output logic [SAMPLE_BITS-1:0]    rsp_right_out
);

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int QW = 2*SAMPLE_BITS + 2*AW + 1;
   localparam longint SMAX_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SMIN_L = -SMAX_L - 1;
   localparam logic signed [LSUM_BITS-1:0] SMAX_W = LSUM_BITS'(SMAX_L);
   localparam logic signed [LSUM_BITS-1:0] SMIN_W = LSUM_BITS'(SMIN_L);
   localparam longint DMAX_L = (longint'(1) <<< (DC_BITS - 1)) - 1;
   localparam longint DMIN_L = -DMAX_L - 1;
   localparam logic signed [YSUM_BITS-1:0] DMAX_W = YSUM_BITS'(DMAX_L);
   localparam logic signed [YSUM_BITS-1:0] DMIN_W = YSUM_BITS'(DMIN_L);

   function automatic logic signed [DC_BITS-1:0] sat_dc(
      input logic signed [YSUM_BITS-1:0] v);
      logic signed [DC_BITS-1:0] r;
      if (v > DMAX_W) begin
         r = DMAX_W[DC_BITS-1:0];
      end else if (v < DMIN_W) begin
         r = DMIN_W[DC_BITS-1:0];
      end else begin
         r = v[DC_BITS-1:0];
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [LSUM_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] r;
      if (v > SMAX_W) begin
         r = SMAX_W[SAMPLE_BITS-1:0];
      end else if (v < SMIN_W) begin
         r = SMIN_W[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   back_state_type state_ff, state_in;

   // queue word fields
   logic                          q_rvalid;
   logic [AW-1:0]                 q_raddr;
   logic [AW-1:0]                 q_waddr;
   logic [SAMPLE_BITS-1:0]        q_right;
   logic [SAMPLE_BITS-1:0]        q_left;

   logic [GAIN_BITS-1:0]          gain_ff, gain_in;
   logic [GAIN_BITS-1:0]          gain_eff;

   logic signed [SAMPLE_BITS-1:0] in_l_ff, in_r_ff;
   logic [AW-1:0]                 waddr_ff;
   logic                          rvalid_ff;
   logic signed [SAMPLE_BITS-1:0] xp_l_ff, xp_r_ff, xp_l_in, xp_r_in;
   logic signed [DC_BITS-1:0]     yp_l_ff, yp_r_ff, yp_l_in, yp_r_in;
   logic signed [PROD_BITS-1:0]   pc_l_ff, pc_r_ff;
   logic signed [PROD_BITS-1:0]   pf_l_ff, pf_r_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]        rsp_l_ff, rsp_r_ff;

   logic [SAMPLE_BITS-1:0]        ram_l_rd, ram_r_rd;
   logic [SAMPLE_BITS-1:0]        wr_l, wr_r;
   logic                          ram_we;
   logic                          load;
   logic                          out_free;

   logic signed [SAMPLE_BITS-1:0] dly_l, dly_r;
   logic signed [PROD_BITS-1:0]   rsum_l, rsum_r, fsum_l, fsum_r;
   logic signed [PROD_BITS-17:0]  rnd_l, rnd_r;
   logic signed [PROD_BITS-16:0]  t_l, t_r;
   logic signed [YSUM_BITS-1:0]   ysum_l, ysum_r;
   logic signed [LSUM_BITS-1:0]   lsum_l, lsum_r;

   assign q_rvalid = q_data[0];
   assign q_raddr  = q_data[AW:1];
   assign q_waddr  = q_data[2*AW:AW+1];
   assign q_right  = q_data[2*AW+SAMPLE_BITS:2*AW+1];
   assign q_left   = q_data[QW-1:2*AW+SAMPLE_BITS+1];

   // feedback gain register; above unity acts as unity
   always_comb begin
      gain_in = gain_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GAIN: gain_in = csr_data[GAIN_BITS-1:0];
            default:  gain_in = gain_ff;
         endcase
      end
   end
   assign gain_eff = (gain_ff > FB_UNITY) ? FB_UNITY : gain_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      ram_we   = 1'b0;
      load     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               state_in = BK_BLOCK;
            end
         end
         BK_BLOCK: state_in = BK_FEED;
         BK_FEED:  state_in = BK_WRITE;
         BK_WRITE: begin
            if (out_free) begin
               ram_we   = 1'b1;
               load     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // blocker: y = x - x_prev + round(c * y_prev), saturated to 32 bits
   always_comb begin
      dly_l  = rvalid_ff ? $signed(ram_l_rd) : '0;
      dly_r  = rvalid_ff ? $signed(ram_r_rd) : '0;
      rsum_l = pc_l_ff + DC_ROUND;
      rsum_r = pc_r_ff + DC_ROUND;
      rnd_l  = $signed(rsum_l[PROD_BITS-1:16]);
      rnd_r  = $signed(rsum_r[PROD_BITS-1:16]);
      ysum_l = YSUM_BITS'(dly_l) - YSUM_BITS'(xp_l_ff) + YSUM_BITS'(rnd_l);
      ysum_r = YSUM_BITS'(dly_r) - YSUM_BITS'(xp_r_ff) + YSUM_BITS'(rnd_r);
      xp_l_in = xp_l_ff;
      xp_r_in = xp_r_ff;
      yp_l_in = yp_l_ff;
      yp_r_in = yp_r_ff;
      if (state_ff == BK_BLOCK) begin
         xp_l_in = dly_l;
         xp_r_in = dly_r;
         yp_l_in = sat_dc(ysum_l);
         yp_r_in = sat_dc(ysum_r);
      end
   end

   // line value: input + round(gain * y), saturated to the sample range
   always_comb begin
      fsum_l = pf_l_ff + FB_ROUND;
      fsum_r = pf_r_ff + FB_ROUND;
      t_l    = $signed(fsum_l[PROD_BITS-1:15]);
      t_r    = $signed(fsum_r[PROD_BITS-1:15]);
      lsum_l = LSUM_BITS'(in_l_ff) + LSUM_BITS'(t_l);
      lsum_r = LSUM_BITS'(in_r_ff) + LSUM_BITS'(t_r);
      wr_l   = sat_sample(lsum_l);
      wr_r   = sat_sample(lsum_r);
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         gain_ff      <= GAIN_RESET;
         xp_l_ff      <= '0;
         xp_r_ff      <= '0;
         yp_l_ff      <= '0;
         yp_r_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         xp_l_ff      <= xp_l_in;
         xp_r_ff      <= xp_r_in;
         yp_l_ff      <= yp_l_in;
         yp_r_ff      <= yp_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // products run every cycle; each is settled before its stage reads it
   always_ff @(posedge clock) begin
      pc_l_ff <= $signed({1'b0, DC_COEF}) * yp_l_ff;
      pc_r_ff <= $signed({1'b0, DC_COEF}) * yp_r_ff;
      pf_l_ff <= $signed({1'b0, gain_eff}) * yp_l_ff;
      pf_r_ff <= $signed({1'b0, gain_eff}) * yp_r_ff;
      if (q_pop) begin
         in_l_ff   <= $signed(q_left);
         in_r_ff   <= $signed(q_right);
         waddr_ff  <= q_waddr;
         rvalid_ff <= q_rvalid;
      end
      if (load) begin
         rsp_l_ff <= xp_l_ff;
         rsp_r_ff <= xp_r_ff;
      end
   end

   sfd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line_left (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (waddr_ff),
      .wr_data (wr_l),
      .rd_en   (q_pop),
      .rd_addr (q_raddr),
      .rd_data (ram_l_rd)
   );

   sfd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line_right (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (waddr_ff),
      .wr_data (wr_r),
      .rd_en   (q_pop),
      .rd_addr (q_raddr),
      .rd_data (ram_r_rd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;

   `SFD_ASSERT_IMPLY(a_block_after_pop, clock, reset, state_ff == BK_BLOCK, $past(q_pop),
      "blocker stage entered without a popped frame")
   `SFD_ASSERT_NEXT(a_write_gives_word, clock, reset, ram_we, rsp_valid_ff,
      "line written without a result word")

endmodule

[src/stereo_feedback_delay_dc_block.sv]
// Top level of the stereo feedback delay with DC blocker on the feedback path.
// Depends on sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Usage:
//   req_* carries one stereo frame per word (req_left_in, req_right_in);
//   a word moves when req_valid is high and req_stall is low.
//   rsp_* returns one word per frame: the samples read delay_samples frames
//   back from the line, unchanged. The word moves when rsp_valid is high and
//   rsp_stall is low.
//   csr_write with csr_index/csr_data sets delay_samples (index 0) or
//   feedback_gain (index 1); write only while the block is idle.
// Processing:
//   The back end takes each frame in order through pop and line read,
//   blocker, feedback multiply and line write, and pops no new frame until
//   the line write of the last one; the result is loaded with the line write.
// Reset and stall:
//   Reset zeros the filter state and the write slot. Line entries never
//   written read as zero through fill tracking, so there is no clearing pass.
//   After reset and after each delay write, req_stall stays high while the
//   delay is reduced modulo the line depth.
//   A stalled result holds in the output register; the two-word queue keeps
//   accepting frames until it fills, then req_stall rises.
module stereo_feedback_delay_dc_block
   import sfd_pkg::*;
#(
   parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_left_in,
   input  logic [SAMPLE_BITS-1:0]    req_right_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SAMPLE_BITS-1:0]    rsp_left_out,
   output logic [SAMPLE_BITS-1:0]    rsp_right_out,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   // queue word: left, right, write slot, read slot, read-slot-written flag
   localparam int AW = $clog2(LINE_DEPTH);
   localparam int QW = 2*SAMPLE_BITS + 2*AW + 1;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   logic [QW-1:0]    q_push_data;
   logic [QW-1:0]    q_pop_data;

   // front: take frames, assign line slots
   sfd_front #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   // decouple: front keeps taking frames while the back end works or stalls, until the queue fills
   sfd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // back: line access, blocker, feedback, result register
   sfd_back #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .q_data        (q_pop_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule
